>>> rtl/core/b64_pkg.sv
`timescale 1ns / 1ps

package b64_pkg;

    localparam int NumSlots = 4;
    localparam int CntW     = 3;

    localparam logic [7:0] ChEq    = 8'h3D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;

    localparam logic ModeEncode = 1'b0;
    localparam logic ModeDecode = 1'b1;

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       error;
        logic       last;
    } result_t;

    typedef result_t [NumSlots-1:0] slots_t;

    typedef struct packed {
        slots_t            items;
        logic [CntW-1:0]   count;
    } step_out_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [5:0] carry;
        logic       pad_seen;
        logic       err_seen;
    } codec_state_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = ChPlus;
        end else begin
            c = ChSlash;
        end
        return c;
    endfunction

    function automatic sextet_t char_sextet(input logic [7:0] c);
        sextet_t r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == ChPlus) begin
            r.val = 6'd62;
        end else if (c == ChSlash) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/base64_codec.sv
`timescale 1ns / 1ps
// the first result word is on the m_ side in the cycle after the input word is taken
// each input word yields 0 to 4 result words, held in a 4-slot buffer and sent one per cycle
// while m_tready is high; throughput: one input word per cycle while each yields at most one
// result, else one per result word sent (encode: 4 words per 3 bytes, up to 4 on a flush)
// reset: synchronous active low aresetn clears mode to encode, the group state and the buffer's word count

module base64_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,    // mode: 0 encode, 1 decode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,        // in_value
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,        // out_value
    output logic [1:0] m_tuser,        // out_valid, out_error
    output logic       m_tlast
);
    import b64_pkg::*;

    logic         mode_reg, mode_next;
    codec_state_t st_reg, st_next, st_step;
    step_out_t    step_res;
    result_t      head;
    logic         accept;

    b64_step u_step (
        .mode     (mode_reg),
        .st       (st_reg),
        .in_value (s_tdata),
        .in_last  (s_tlast),
        .res      (step_res),
        .st_next  (st_step)
    );

    b64_out_buf u_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (s_tvalid),
        .load_ready (s_tready),
        .load_data  (step_res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_head     (head)
    );

    assign accept  = s_tvalid && s_tready;
    assign m_tdata = head.value;
    assign m_tuser = {head.error, head.valid};
    assign m_tlast = head.last;

    always_comb begin
        mode_next = mode_reg;
        st_next   = st_reg;
        if (cfg_wr_en) begin
            mode_next = cfg_wr_data;
            st_next   = '0;
        end else if (accept) begin
            st_next = st_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ModeEncode;
            st_reg   <= '0;
        end else begin
            mode_reg <= mode_next;
            st_reg   <= st_next;
        end
    end

endmodule

>>> rtl/core/b64_step.sv
`timescale 1ns / 1ps

module b64_step (
    input  logic                  mode,
    input  b64_pkg::codec_state_t st,
    input  logic [7:0]            in_value,
    input  logic                  in_last,
    output b64_pkg::step_out_t    res,
    output b64_pkg::codec_state_t st_next
);
    import b64_pkg::*;

    logic [CntW-1:0] n;
    logic            ws;
    sextet_t         sx;
    result_t         r;

    always_comb begin
        res     = '0;
        st_next = st;
        n       = '0;
        r       = '0;
        ws      = (in_value == ChSpace) || (in_value == ChTab) ||
                  (in_value == ChCr) || (in_value == ChLf);
        sx      = char_sextet(in_value);

        if (mode == ModeEncode) begin
            r.valid = 1'b1;
            case (st.phase)
                2'd1: begin
                    r.value = sextet_char({st.carry[1:0], in_value[7:4]});
                    res.items[0] = r;
                    n = 3'd1;
                    st_next.carry = {2'b00, in_value[3:0]};
                    st_next.phase = 2'd2;
                end
                2'd2: begin
                    r.value = sextet_char({st.carry[3:0], in_value[7:6]});
                    res.items[0] = r;
                    r.value = sextet_char(in_value[5:0]);
                    res.items[1] = r;
                    n = 3'd2;
                    st_next.carry = '0;
                    st_next.phase = 2'd0;
                end
                default: begin
                    r.value = sextet_char(in_value[7:2]);
                    res.items[0] = r;
                    n = 3'd1;
                    st_next.carry = {4'b0000, in_value[1:0]};
                    st_next.phase = 2'd1;
                end
            endcase
            if (in_last) begin
                // flush leftover bits and pad the group to four characters
                if (st_next.phase == 2'd1) begin
                    r.value = sextet_char({st_next.carry[1:0], 4'b0000});
                    res.items[1] = r;
                    r.value = ChEq;
                    res.items[2] = r;
                    res.items[3] = r;
                    n = 3'd4;
                end else if (st_next.phase == 2'd2) begin
                    r.value = sextet_char({st_next.carry[3:0], 2'b00});
                    res.items[1] = r;
                    r.value = ChEq;
                    res.items[2] = r;
                    n = 3'd3;
                end
            end
        end else begin
            if (!st.err_seen && !st.pad_seen && !ws) begin
                if (in_value == ChEq) begin
                    st_next.pad_seen = 1'b1;
                end else if (!sx.ok) begin
                    r.error = 1'b1;
                    res.items[0] = r;
                    n = 3'd1;
                    st_next.err_seen = 1'b1;
                end else begin
                    r.valid = 1'b1;
                    case (st.phase)
                        2'd0: begin
                            st_next.carry = sx.val;
                            st_next.phase = 2'd1;
                        end
                        2'd1: begin
                            r.value = {st.carry, sx.val[5:4]};
                            res.items[0] = r;
                            n = 3'd1;
                            st_next.carry = {2'b00, sx.val[3:0]};
                            st_next.phase = 2'd2;
                        end
                        2'd2: begin
                            r.value = {st.carry[3:0], sx.val[5:2]};
                            res.items[0] = r;
                            n = 3'd1;
                            st_next.carry = {4'b0000, sx.val[1:0]};
                            st_next.phase = 2'd3;
                        end
                        default: begin
                            r.value = {st.carry[1:0], sx.val};
                            res.items[0] = r;
                            n = 3'd1;
                            st_next.carry = '0;
                            st_next.phase = 2'd0;
                        end
                    endcase
                end
            end
            // marker word so the last item always shows up at the output
            if (in_last && n == 3'd0) begin
                res.items[0] = '0;
                n = 3'd1;
            end
        end

        if (in_last) begin
            res.items[2'(n - 3'd1)].last = 1'b1;
            st_next = '0;
        end
        res.count = n;
    end

endmodule

>>> rtl/core/b64_out_buf.sv
`timescale 1ns / 1ps

module b64_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_valid,
    output logic               load_ready,
    input  b64_pkg::step_out_t load_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output b64_pkg::result_t   m_head
);
    import b64_pkg::*;

    slots_t          slot_reg, slot_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            pop;
    logic            load;

    assign m_tvalid   = (cnt_reg != '0);
    assign pop        = m_tvalid && m_tready;
    // take a new item when empty or while the final word of the previous one leaves
    assign load_ready = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_tready);
    assign load       = load_valid && load_ready;
    assign m_head     = slot_reg[0];

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            slot_next = load_data.items;
            cnt_next  = load_data.count;
        end else if (pop) begin
            slot_next = {result_t'('0), slot_reg[NumSlots-1:1]};
            cnt_next  = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(NumSlots))
        else $error("word count out of range");

    a_last_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_head.last) |-> (cnt_reg == CntW'(1)))
        else $error("last flag on a word that is not the final one");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !load) |=> (cnt_reg == $past(cnt_reg) - CntW'(1)))
        else $error("word count did not step down on a pop");

endmodule

>>> tb/tb_base64_codec.sv
`timescale 1ns / 1ps

module tb_base64_codec;

    import b64_pkg::*;

    localparam int StallLimit = 4000;
    localparam int DirRows    = 25;
    localparam int BlockWords = 16;

    typedef struct {
        logic       mode;
        logic [7:0] value;
        logic       last;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;        // in_value
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;        // out_value
    logic [1:0] m_tuser;        // out_valid, out_error
    logic       m_tlast;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // codec state as seen by the predictor
    logic       cur_mode  = ModeEncode;
    logic [1:0] cur_phase = 2'd0;
    logic [5:0] cur_carry = 6'd0;
    bit         cur_pad   = 1'b0;
    bit         cur_err   = 1'b0;

    result_t    step_words[$];
    result_t    due_words[$];

    int send_idle   = 22;
    int sink_stall  = 83;
    int mismatches  = 0;
    int words_in    = 0;
    int words_out   = 0;
    int quiet_count = 0;

    dir_row_t dir_tab [DirRows] = '{
        '{ModeEncode, 8'h00,   1'b0, 1'b1, '{"A",     1'b1, 1'b0, 1'b0}},
        '{ModeEncode, 8'h00,   1'b0, 1'b0, '0},
        '{ModeEncode, 8'hFF,   1'b0, 1'b0, '0},
        '{ModeEncode, 8'hFF,   1'b0, 1'b1, '{ChSlash, 1'b1, 1'b0, 1'b0}},
        '{ModeEncode, 8'h0F,   1'b1, 1'b0, '0},
        '{ModeEncode, 8'hFB,   1'b1, 1'b0, '0},
        '{ModeDecode, ChSpace, 1'b0, 1'b0, '0},
        '{ModeDecode, ChPlus,  1'b0, 1'b0, '0},
        '{ModeDecode, ChTab,   1'b0, 1'b0, '0},
        '{ModeDecode, ChSlash, 1'b0, 1'b0, '0},
        '{ModeDecode, ChCr,    1'b0, 1'b0, '0},
        '{ModeDecode, "8",     1'b0, 1'b0, '0},
        '{ModeDecode, ChEq,    1'b0, 1'b0, '0},
        '{ModeDecode, "A",     1'b0, 1'b0, '0},
        '{ModeDecode, ChLf,    1'b1, 1'b0, '0},
        '{ModeDecode, 8'h80,   1'b0, 1'b1, '{8'h00,   1'b0, 1'b1, 1'b0}},
        '{ModeDecode, "B",     1'b0, 1'b0, '0},
        '{ModeDecode, "z",     1'b1, 1'b1, '{8'h00,   1'b0, 1'b0, 1'b1}},
        '{ModeDecode, 8'hFF,   1'b0, 1'b1, '{8'h00,   1'b0, 1'b1, 1'b0}},
        '{ModeDecode, ChEq,    1'b1, 1'b1, '{8'h00,   1'b0, 1'b0, 1'b1}},
        '{ModeDecode, ChSpace, 1'b1, 1'b1, '{8'h00,   1'b0, 1'b0, 1'b1}},
        '{ModeDecode, "0",     1'b0, 1'b0, '0},
        '{ModeDecode, "9",     1'b0, 1'b0, '0},
        '{ModeDecode, "a",     1'b0, 1'b0, '0},
        '{ModeDecode, "Z",     1'b1, 1'b0, '0}
    };

    base64_codec u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
        return alphabet[s];
    endfunction

    function automatic int ascii_to_sextet(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (alphabet[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: begin
                return ChSpace;
            end
            1: begin
                return ChTab;
            end
            2: begin
                return ChCr;
            end
            default: begin
                return ChLf;
            end
        endcase
    endfunction

    function automatic void emit(input logic [7:0] val, input logic ok, input logic bad);
        result_t r;
        r.value = val;
        r.valid = ok;
        r.error = bad;
        r.last  = 1'b0;
        step_words.push_back(r);
    endfunction

    function automatic void clear_group();
        cur_phase = 2'd0;
        cur_carry = 6'd0;
        cur_pad   = 1'b0;
        cur_err   = 1'b0;
    endfunction

    // result words that one input word produces, left in step_words
    function automatic void codec_step(input logic [7:0] v, input logic lst);
        int         s;
        logic [5:0] u;
        step_words.delete();
        if (cur_mode == ModeEncode) begin
            case (cur_phase)
                2'd1: begin
                    emit(sextet_to_ascii({cur_carry[1:0], v[7:4]}), 1'b1, 1'b0);
                    cur_carry = {2'b00, v[3:0]};
                    cur_phase = 2'd2;
                end
                2'd2: begin
                    emit(sextet_to_ascii({cur_carry[3:0], v[7:6]}), 1'b1, 1'b0);
                    emit(sextet_to_ascii(v[5:0]), 1'b1, 1'b0);
                    cur_carry = 6'd0;
                    cur_phase = 2'd0;
                end
                default: begin
                    emit(sextet_to_ascii(v[7:2]), 1'b1, 1'b0);
                    cur_carry = {4'b0000, v[1:0]};
                    cur_phase = 2'd1;
                end
            endcase
            if (lst && cur_phase == 2'd1) begin
                emit(sextet_to_ascii({cur_carry[1:0], 4'b0000}), 1'b1, 1'b0);
                emit(ChEq, 1'b1, 1'b0);
                emit(ChEq, 1'b1, 1'b0);
            end else if (lst && cur_phase == 2'd2) begin
                emit(sextet_to_ascii({cur_carry[3:0], 2'b00}), 1'b1, 1'b0);
                emit(ChEq, 1'b1, 1'b0);
            end
        end else begin
            if (!cur_err && !cur_pad && !is_blank(v)) begin
                s = ascii_to_sextet(v);
                if (v == ChEq) begin
                    cur_pad = 1'b1;
                end else if (s < 0) begin
                    emit(8'h00, 1'b0, 1'b1);
                    cur_err = 1'b1;
                end else begin
                    u = s[5:0];
                    case (cur_phase)
                        2'd0: begin
                            cur_carry = u;
                            cur_phase = 2'd1;
                        end
                        2'd1: begin
                            emit({cur_carry, u[5:4]}, 1'b1, 1'b0);
                            cur_carry = {2'b00, u[3:0]};
                            cur_phase = 2'd2;
                        end
                        2'd2: begin
                            emit({cur_carry[3:0], u[5:2]}, 1'b1, 1'b0);
                            cur_carry = {4'b0000, u[1:0]};
                            cur_phase = 2'd3;
                        end
                        default: begin
                            emit({cur_carry[1:0], u}, 1'b1, 1'b0);
                            cur_carry = 6'd0;
                            cur_phase = 2'd0;
                        end
                    endcase
                end
            end
            // a last word that produced nothing still closes the message
            if (lst && step_words.size() == 0) begin
                emit(8'h00, 1'b0, 1'b0);
            end
        end
        if (lst) begin
            step_words[step_words.size() - 1].last = 1'b1;
            clear_group();
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_word(input logic [7:0] v, input logic lst, input bit typed,
                             input result_t want);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = lst;
        do @(posedge aclk); while (!s_tready);
        words_in++;
        codec_step(v, lst);
        if (typed) begin
            due_words.push_back(want);
        end else begin
            foreach (step_words[i]) begin
                due_words.push_back(step_words[i]);
            end
        end
    endtask

    // hold the sender until every result word is out
    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (due_words.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_mode(input logic m);
        hold_until_drained();
        @(negedge aclk);
        cfg_wr_data = m;
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        cur_mode    = m;
        clear_group();
    endtask

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_stall);
    end

    always @(posedge aclk) begin : check_out
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (due_words.size() == 0) begin
                flag_mismatch($sformatf("word with nothing pending: data %02h user %b last %b",
                                        m_tdata, m_tuser, m_tlast));
            end else begin
                want = due_words.pop_front();
                if (m_tdata !== want.value || m_tuser[0] !== want.valid ||
                    m_tuser[1] !== want.error || m_tlast !== want.last) begin
                    flag_mismatch($sformatf(
                        "out word %0d: data %02h valid %b error %b last %b, want %02h %b %b %b",
                        words_out, m_tdata, m_tuser[0], m_tuser[1], m_tlast,
                        want.value, want.valid, want.error, want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= StallLimit) begin
            $display("%0t ns: no handshake for %0d cycles", $time, StallLimit);
            $display("base64_codec regression: fail");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        logic [7:0] msg[$];
        int         sent;
        int         len;
        int         r;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = ModeEncode;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // first rows run on the reset mode, no write needed
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != cur_mode) begin
                set_mode(dir_tab[i].mode);
            end
            send_word(dir_tab[i].value, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int blk = 0; blk < 6; blk++) begin
            if (blk == 2) begin
                send_idle  = 83;
                sink_stall = 22;
            end else if (blk == 4) begin
                send_idle  = 0;
                sink_stall = 0;
            end
            set_mode(blk[0] ? ModeDecode : ModeEncode);
            sent = 0;
            while (sent < BlockWords) begin
                msg.delete();
                if (!cur_mode) begin
                    len = $urandom_range(1, 7);
                    repeat (len) msg.push_back(8'($urandom_range(255)));
                end else if ($urandom_range(3) != 0) begin
                    // alphabet characters with the odd blank and optional padding
                    len = $urandom_range(1, 8);
                    repeat (len) begin
                        if ($urandom_range(9) == 0) begin
                            msg.push_back(pick_blank());
                        end
                        msg.push_back(alphabet[$urandom_range(63)]);
                    end
                    if ($urandom_range(1) == 1) begin
                        repeat ((4 - len % 4) % 4) msg.push_back(ChEq);
                    end
                end else begin
                    len = $urandom_range(1, 8);
                    repeat (len) begin
                        r = $urandom_range(99);
                        if (r < 60) begin
                            msg.push_back(alphabet[$urandom_range(63)]);
                        end else if (r < 75) begin
                            msg.push_back(pick_blank());
                        end else if (r < 85) begin
                            msg.push_back(ChEq);
                        end else begin
                            msg.push_back(8'($urandom_range(255)));
                        end
                    end
                end
                foreach (msg[i]) begin
                    send_word(msg[i], i == msg.size() - 1, 1'b0, '0);
                    sent++;
                end
                if ($urandom_range(7) == 0) begin
                    hold_until_drained();
                end
            end
        end

        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (due_words.size() != 0) begin
            flag_mismatch($sformatf("%0d result words never came", due_words.size()));
        end
        $display("run: %0d input words, %0d result words, encode and decode messages", words_in,
                 words_out);
        $display("run: blanks, padding, bad characters and flushes under three stall profiles");
        if (mismatches == 0) begin
            $display("base64_codec regression: pass");
        end else begin
            $display("base64_codec regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/b64_pkg.sv
rtl/core/b64_step.sv
rtl/core/b64_out_buf.sv
rtl/core/base64_codec.sv
tb/tb_base64_codec.sv
